@@ sv/packet_block_placement_engine_core_assert.svh @@
`ifndef PACKET_BLOCK_PLACEMENT_ENGINE_CORE_ASSERT_SVH
`define PACKET_BLOCK_PLACEMENT_ENGINE_CORE_ASSERT_SVH
// assertion helpers
`define PBPE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PBPE_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

@@ sv/pbpe_pkg.sv @@
package pbpe_pkg;
  typedef enum logic [2:0] {
    ACT_WRITE       = 3'd0,
    ACT_STASH       = 3'd1,
    ACT_DROP_LATE   = 3'd2,
    ACT_DROP_FULL   = 3'd3,
    ACT_BLOCK_DONE  = 3'd4,
    ACT_REPLAY_WR   = 3'd5,
    ACT_REPLAY_DROP = 3'd6,
    ACT_SKIP        = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    CFG_START_SEQ  = 3'd0,
    CFG_ARMED      = 3'd1,
    CFG_BLOCK_PKTS = 3'd2,
    CFG_MISS_LIMIT = 3'd3,
    CFG_BAD_LIMIT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL    = 7'b0000010,
    ST_PLACE  = 7'b0000100,
    ST_CLOSE  = 7'b0001000,
    ST_RDREQ  = 7'b0010000,
    ST_REPLAY = 7'b0100000,
    ST_SKIP   = 7'b1000000
  } state_e;

  localparam logic [20:0] BLOCK_MAX = 21'd1048576;
  localparam logic [3:0]  LOCK_TARGET = 4'd10;
  localparam logic [3:0]  LOCK_MAX = 4'd15;
  localparam logic [35:0] LOCK_WINDOW = 36'd50;
endpackage

@@ sv/pbpe_ram.sv @@
module pbpe_ram #(
  parameter int Width = 64,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ sv/packet_block_placement_engine_core.sv @@
// Flow: an accepted header passes through ST_MUL and ST_PLACE into the output
// register; when the first block opens, ST_PLACE runs once more. Block close
// adds ST_CLOSE, each replayed stash entry ST_RDREQ and ST_REPLAY (one stash
// RAM read), each skipped block ST_SKIP. A new header is taken only in ST_IDLE
// once the last result leaves the output register.
// Reset: rst_ni asynchronous active low clears control and counters.
`include "packet_block_placement_engine_core_assert.svh"
module packet_block_placement_engine_core #(
  parameter int ChannelsPerGroup = 384,
  parameter int BoardCount = 32,
  parameter int StashDepth = 8,
  parameter int SkipBlocks = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] header_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  action_o,
  output logic [19:0] block_offset_o,
  output logic [3:0]  stash_slot_o,
  output logic [20:0] missing_count_o,
  output logic [63:0] dropped_total_o,
  output logic [63:0] received_total_o,
  output logic        last_o
);
  localparam int SW = (StashDepth > 1) ? $clog2(StashDepth) : 1;
  localparam int RW = $clog2(StashDepth + 1);
  localparam int SkW = $clog2(SkipBlocks + 1);
  localparam logic [63:0] CbMul = 64'(ChannelsPerGroup * BoardCount);
  localparam logic [31:0] AntMul = 32'(ChannelsPerGroup);
  localparam logic [63:0] Recip3 = 64'h0000_0000_AAAA_AAAB;
  localparam logic [RW-1:0] StashFull = RW'(StashDepth);
  localparam logic [SkW-1:0] SkipLast = SkW'(SkipBlocks - 1);

  logic [34:0] start_seq_q;
  logic        armed_q;
  logic [20:0] blk_pkts_q, miss_lim_q;
  logic [7:0]  bad_lim_q;

  pbpe_pkg::state_e st_q;
  logic        wen_q, started_q;
  logic [3:0]  lock_q;
  logic [63:0] first_q, lastidx_q, drop_q, recv_q, sprod_q;
  logic [20:0] fill_q;
  logic [RW-1:0] sfill_q, ri_q;
  logic [SkW-1:0] sk_q;
  logic [7:0]  bad_q;
  logic [34:0] seq_q, latest_q;
  logic [31:0] aprod_q, aquot_q;

  logic        ov_q;
  logic [2:0]  oact_q;
  logic [19:0] ooff_q;
  logic [3:0]  oslot_q;
  logic [20:0] omiss_q;
  logic        olast_q;

  logic        ram_we;
  logic [SW-1:0] ram_wa, ram_ra;
  logic [63:0] ram_rd;
  logic [63:0] idx;

  pbpe_ram #(.Width(64), .Depth(StashDepth)) u_stash (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(idx),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  logic [20:0] cfg_bp;
  always_comb begin
    cfg_bp = cfg_data_i[20:0];
    if (cfg_bp == 21'd0) cfg_bp = 21'd1;
    if (cfg_bp > pbpe_pkg::BLOCK_MAX) cfg_bp = pbpe_pkg::BLOCK_MAX;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_seq_q <= '0;
      armed_q <= 1'b0;
      blk_pkts_q <= 21'd1024;
      miss_lim_q <= 21'd1000;
      bad_lim_q <= 8'd50;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pbpe_pkg::CFG_START_SEQ:  start_seq_q <= cfg_data_i[34:0];
        pbpe_pkg::CFG_ARMED:      armed_q <= cfg_data_i[0];
        pbpe_pkg::CFG_BLOCK_PKTS: blk_pkts_q <= cfg_bp;
        pbpe_pkg::CFG_MISS_LIMIT: miss_lim_q <= cfg_data_i[20:0];
        pbpe_pkg::CFG_BAD_LIMIT:  bad_lim_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [63:0] nfirst, nlast, roff, start_idx;
  logic [20:0] miss;
  logic        out_free, p_late, p_write, p_stash, p_close, skip_due, bad_inc;
  logic [7:0]  bad_nx;
  logic [RW-1:0] ri_nx;
  assign nfirst = lastidx_q + 64'd1;
  assign nlast = nfirst + 64'(blk_pkts_q - 21'd1);
  assign miss = (fill_q < blk_pkts_q) ? blk_pkts_q - fill_q : 21'd0;
  assign roff = ram_rd - first_q;
  assign start_idx = (64'(start_seq_q) * CbMul) >> 1;
  assign idx = sprod_q + 64'(aquot_q);

  assign out_free = !ov_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign in_ready_o = (st_q == pbpe_pkg::ST_IDLE) && !ov_q;

  assign p_late = idx < first_q;
  assign p_write = !p_late && (idx <= lastidx_q);
  assign p_stash = !p_late && !p_write && (sfill_q < StashFull);
  assign p_close = (fill_q + 21'(p_write) >= blk_pkts_q) ||
                   (sfill_q + RW'(p_stash) >= StashFull);
  assign skip_due = bad_q > bad_lim_q;
  assign bad_inc = (miss > miss_lim_q) && (bad_q != 8'd255);
  assign bad_nx = bad_q + 8'(bad_inc);
  assign ri_nx = ri_q + RW'(1);

  assign ram_ra = ri_q[SW-1:0];
  assign ram_wa = sfill_q[SW-1:0];
  assign ram_we = (st_q == pbpe_pkg::ST_PLACE) && wen_q && started_q && out_free && p_stash;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pbpe_pkg::ST_IDLE;
      wen_q <= 1'b0; started_q <= 1'b0; lock_q <= '0;
      first_q <= '0; lastidx_q <= '0; fill_q <= '0; sfill_q <= '0;
      bad_q <= '0; drop_q <= '0; recv_q <= '0; latest_q <= '0;
      ri_q <= '0; sk_q <= '0; ov_q <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (st_q)
        pbpe_pkg::ST_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            seq_q <= header_word_i[63:29];
            aprod_q <= 32'(header_word_i[15:0]) * AntMul;
            st_q <= pbpe_pkg::ST_MUL;
          end
        end
        pbpe_pkg::ST_MUL: begin
          sprod_q <= (64'(seq_q) * CbMul) >> 1;
          aquot_q <= 32'((64'(aprod_q) * Recip3) >> 33);
          latest_q <= seq_q;
          if (!wen_q) begin
            if (armed_q && ({1'b0, seq_q} + pbpe_pkg::LOCK_WINDOW >= {1'b0, start_seq_q})
                && lock_q < pbpe_pkg::LOCK_MAX) begin
              lock_q <= lock_q + 4'd1;
              if (lock_q + 4'd1 >= pbpe_pkg::LOCK_TARGET) wen_q <= 1'b1;
            end else if (lock_q >= pbpe_pkg::LOCK_TARGET) wen_q <= 1'b1;
          end
          st_q <= pbpe_pkg::ST_PLACE;
        end
        pbpe_pkg::ST_PLACE: begin
          if (!wen_q) begin
            st_q <= pbpe_pkg::ST_IDLE;
          end else if (!started_q) begin
            first_q <= start_idx;
            lastidx_q <= start_idx + 64'(blk_pkts_q - 21'd1);
            started_q <= 1'b1;
          end else if (out_free) begin
            ov_q <= 1'b1;
            ooff_q <= '0; oslot_q <= '0; omiss_q <= '0;
            olast_q <= !(p_close || skip_due);
            if (p_late) begin
              drop_q <= drop_q + 64'd1;
              oact_q <= pbpe_pkg::ACT_DROP_LATE;
            end else if (p_write) begin
              recv_q <= recv_q + 64'd1;
              fill_q <= fill_q + 21'd1;
              oact_q <= pbpe_pkg::ACT_WRITE;
              ooff_q <= 20'(idx - first_q);
            end else if (p_stash) begin
              oact_q <= pbpe_pkg::ACT_STASH;
              oslot_q <= 4'(sfill_q);
              sfill_q <= sfill_q + RW'(1);
            end else begin
              drop_q <= drop_q + 64'd1;
              oact_q <= pbpe_pkg::ACT_DROP_FULL;
            end
            if (p_close) begin
              st_q <= pbpe_pkg::ST_CLOSE;
            end else if (skip_due) begin
              sk_q <= '0;
              st_q <= pbpe_pkg::ST_SKIP;
            end else begin
              st_q <= pbpe_pkg::ST_IDLE;
            end
          end
        end
        pbpe_pkg::ST_CLOSE: begin
          if (out_free) begin
            drop_q <= drop_q + 64'(miss);
            bad_q <= bad_nx;
            ov_q <= 1'b1;
            oact_q <= pbpe_pkg::ACT_BLOCK_DONE;
            ooff_q <= '0; oslot_q <= '0; omiss_q <= miss;
            olast_q <= !((sfill_q != '0) || (bad_nx > bad_lim_q));
            first_q <= nfirst; lastidx_q <= nlast; fill_q <= '0;
            ri_q <= '0;
            if (sfill_q != '0) begin
              st_q <= pbpe_pkg::ST_RDREQ;
            end else if (bad_nx > bad_lim_q) begin
              sk_q <= '0;
              st_q <= pbpe_pkg::ST_SKIP;
            end else begin
              st_q <= pbpe_pkg::ST_IDLE;
            end
          end
        end
        pbpe_pkg::ST_RDREQ: begin
          st_q <= pbpe_pkg::ST_REPLAY;
        end
        pbpe_pkg::ST_REPLAY: begin
          if (out_free) begin
            ov_q <= 1'b1;
            ooff_q <= '0; omiss_q <= '0;
            oslot_q <= 4'(ri_q);
            olast_q <= (ri_nx == sfill_q) && !skip_due;
            if (ram_rd >= first_q && roff < 64'(blk_pkts_q)) begin
              fill_q <= fill_q + 21'd1;
              recv_q <= recv_q + 64'd1;
              oact_q <= pbpe_pkg::ACT_REPLAY_WR;
              ooff_q <= 20'(roff);
            end else begin
              drop_q <= drop_q + 64'd1;
              oact_q <= pbpe_pkg::ACT_REPLAY_DROP;
            end
            ri_q <= ri_nx;
            if (ri_nx == sfill_q) begin
              sfill_q <= '0;
              if (skip_due) begin
                sk_q <= '0;
                st_q <= pbpe_pkg::ST_SKIP;
              end else begin
                st_q <= pbpe_pkg::ST_IDLE;
              end
            end else begin
              st_q <= pbpe_pkg::ST_RDREQ;
            end
          end
        end
        pbpe_pkg::ST_SKIP: begin
          if (out_free) begin
            drop_q <= drop_q + 64'(blk_pkts_q);
            ov_q <= 1'b1;
            oact_q <= pbpe_pkg::ACT_SKIP;
            ooff_q <= '0; oslot_q <= '0; omiss_q <= blk_pkts_q;
            olast_q <= (sk_q == SkipLast);
            first_q <= nfirst; lastidx_q <= nlast; fill_q <= '0;
            sk_q <= sk_q + SkW'(1);
            if (sk_q == SkipLast) begin
              bad_q <= '0;
              st_q <= pbpe_pkg::ST_IDLE;
            end
          end
        end
        default: st_q <= pbpe_pkg::ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign action_o = oact_q;
  assign block_offset_o = ooff_q;
  assign stash_slot_o = oslot_q;
  assign missing_count_o = omiss_q;
  assign dropped_total_o = drop_q;
  assign received_total_o = recv_q;
  assign last_o = olast_q;

  `PBPE_ASSERT(a_stash_bound, clk_i, rst_ni, sfill_q <= StashFull, "stash overfilled")
  `PBPE_ASSERT_NEXT(a_no_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o,
    st_q == pbpe_pkg::ST_MUL, "accept did not start work")
  `PBPE_ASSERT(a_ram_we_room, clk_i, rst_ni, !ram_we || sfill_q < StashFull,
    "stash write when full")
endmodule
